>>> rtl/lpcp_pkg.sv
package lpcp_pkg;

    localparam int CoefW   = 32;
    localparam int CoordW  = 32;
    localparam int ProdW   = 64;
    localparam int AccW    = 66;
    localparam int MagW    = 65;
    localparam int SizeW   = 13;
    localparam int PixW    = 12;
    localparam int QuotW   = 13;
    localparam int NumRegs = 8;
    localparam int RegIdxW = 3;
    localparam int CfgW    = 64;

    localparam logic [RegIdxW-1:0] RegWidth  = 3'd6;
    localparam logic [RegIdxW-1:0] RegHeight = 3'd7;

    localparam logic [SizeW-1:0] SizeMax     = 13'd4096;
    localparam logic [SizeW-1:0] WidthReset  = 13'd640;
    localparam logic [SizeW-1:0] HeightReset = 13'd480;

    typedef struct packed {
        logic [CoordW-1:0] x;
        logic [CoordW-1:0] y;
        logic [CoordW-1:0] z;
        logic              last;
    } point_t;

    typedef struct packed {
        logic            u_neg;
        logic            v_neg;
        logic            w_neg;
        logic            u_zero;
        logic            v_zero;
        logic            w_zero;
        logic            x_neg;
        logic [MagW-1:0] u_mag;
        logic [MagW-1:0] v_mag;
        logic [MagW-1:0] w_mag;
    } proj_t;

    typedef struct packed {
        logic [MagW-1:0]  rem_u;
        logic [MagW-1:0]  rem_v;
        logic [MagW-1:0]  den;
        logic [QuotW-1:0] q_u;
        logic [QuotW-1:0] q_v;
        logic             ok;
    } div_t;

endpackage

>>> rtl/lidar_point_camera_projection_core.sv
// Projects one lidar point per cycle through a 3x4 camera matrix. A new point
// can be taken every cycle; the path from input transfer to result runs
// through two multiply/sum stages, one sign/magnitude stage, a row of
// 13 restoring divider cells (one quotient bit each) and the output register.
// The whole pipeline advances only when the output register can take data.
module lidar_point_camera_projection_core (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [95:0]  s_tdata,   // point_x, point_y, point_z
    input  logic         s_tlast,   // cloud_end
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [127:0] m_tdata,   // in_view, pixel_row, pixel_column, out_x, out_y, out_z
    output logic         m_tlast,   // scan_end
    input  logic         cfg_we,
    input  logic [2:0]   cfg_index,
    input  logic [63:0]  cfg_data
);
    import lpcp_pkg::*;

    localparam int Depth = 4 + QuotW;

    logic [CfgW-1:0]  coef_reg [6];
    logic [SizeW-1:0] width_reg;
    logic [SizeW-1:0] height_reg;
    logic [Depth-1:0] vld_reg;
    logic             adv;

    assign adv      = !m_tvalid || m_tready;
    assign s_tready = adv;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 6; i++) coef_reg[i] <= '0;
            width_reg  <= WidthReset;
            height_reg <= HeightReset;
        end else if (cfg_we) begin
            if (cfg_index < RegWidth) coef_reg[cfg_index] <= cfg_data;
            else if (cfg_index == RegWidth) width_reg <= cfg_data[SizeW-1:0];
            else height_reg <= cfg_data[SizeW-1:0];
        end
    end

    point_t p0;
    point_t p1_reg;
    point_t p2_reg;
    point_t p3_reg;
    assign p0 = '{x: s_tdata[31:0], y: s_tdata[63:32], z: s_tdata[95:64], last: s_tlast};

    logic signed [AccW-1:0] su;
    logic signed [AccW-1:0] sv;
    logic signed [AccW-1:0] sw;

    lpcp_row_mac u_mac_u (.aclk, .en(adv), .pair_a(coef_reg[0]), .pair_b(coef_reg[1]),
        .p_in(p0), .sum(su));
    lpcp_row_mac u_mac_v (.aclk, .en(adv), .pair_a(coef_reg[2]), .pair_b(coef_reg[3]),
        .p_in(p0), .sum(sv));
    lpcp_row_mac u_mac_w (.aclk, .en(adv), .pair_a(coef_reg[4]), .pair_b(coef_reg[5]),
        .p_in(p0), .sum(sw));

    proj_t pr_reg;
    logic [MagW-1:0] mu, mv, mw;
    always_comb begin
        mu = su[AccW-1] ? MagW'(-su) : MagW'(su);
        mv = sv[AccW-1] ? MagW'(-sv) : MagW'(sv);
        mw = sw[AccW-1] ? MagW'(-sw) : MagW'(sw);
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            p1_reg <= p0;
            p2_reg <= p1_reg;
            p3_reg <= p2_reg;
            pr_reg <= '{u_neg: su[AccW-1], v_neg: sv[AccW-1], w_neg: sw[AccW-1],
                u_zero: su == '0, v_zero: sv == '0, w_zero: sw == '0,
                x_neg: p2_reg.x[CoordW-1], u_mag: mu, v_mag: mv, w_mag: mw};
        end
    end

    div_t   d0;
    div_t   dc [QuotW+1];
    point_t pc [QuotW+1];

    always_comb begin
        d0.rem_u = pr_reg.u_mag;
        d0.rem_v = pr_reg.v_mag;
        d0.den   = pr_reg.w_mag;
        d0.q_u   = '0;
        d0.q_v   = '0;
        d0.ok    = !pr_reg.x_neg && !pr_reg.w_zero
                 && (pr_reg.u_zero || pr_reg.u_neg == pr_reg.w_neg)
                 && (pr_reg.v_zero || pr_reg.v_neg == pr_reg.w_neg);
    end
    assign dc[0] = d0;
    assign pc[0] = p3_reg;

    for (genvar g = 0; g < QuotW; g++) begin : g_div
        lpcp_div_cell #(.BitPos(QuotW - 1 - g)) u_cell (
            .aclk, .en(adv), .d_in(dc[g]), .p_in(pc[g]), .d_out(dc[g+1]), .p_out(pc[g+1]));
    end

    logic [SizeW-1:0] wb, hb;
    logic             fit_u, fit_v;
    logic             all_ok;
    logic             in_view_reg;
    logic [PixW-1:0]  row_reg, col_reg;
    point_t           po_reg;

    always_comb begin
        wb     = (width_reg > SizeMax) ? SizeMax : width_reg;
        hb     = (height_reg > SizeMax) ? SizeMax : height_reg;
        // Quotient bits above QuotW are caught when the final remainder is not below the divisor.
        fit_u  = dc[QuotW].rem_u < dc[QuotW].den && dc[QuotW].q_u < wb;
        fit_v  = dc[QuotW].rem_v < dc[QuotW].den && dc[QuotW].q_v < hb;
        all_ok = dc[QuotW].ok && fit_u && fit_v;
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            in_view_reg <= all_ok;
            row_reg     <= all_ok ? dc[QuotW].q_v[PixW-1:0] : '0;
            col_reg     <= all_ok ? dc[QuotW].q_u[PixW-1:0] : '0;
            po_reg      <= pc[QuotW];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) vld_reg <= '0;
        else if (adv) vld_reg <= {vld_reg[Depth-2:0], s_tvalid};
    end

    assign m_tvalid = vld_reg[Depth-1];
    assign m_tdata  = {7'd0, po_reg.z, po_reg.y, po_reg.x, col_reg, row_reg, in_view_reg};
    assign m_tlast  = po_reg.last;
endmodule

>>> rtl/lpcp_div_cell.sv
module lpcp_div_cell #(
    parameter int BitPos = 0
) (
    input  logic          aclk,
    input  logic          en,
    input  lpcp_pkg::div_t d_in,
    input  lpcp_pkg::point_t p_in,
    output lpcp_pkg::div_t d_out,
    output lpcp_pkg::point_t p_out
);
    import lpcp_pkg::*;

    localparam int TrialW = MagW + QuotW;

    logic [TrialW-1:0] den_sh;
    logic [TrialW-1:0] ru;
    logic [TrialW-1:0] rv;
    logic              ge_u;
    logic              ge_v;
    div_t              d_next;
    div_t              d_reg;
    point_t            p_reg;

    always_comb begin
        den_sh = {{QuotW{1'b0}}, d_in.den} << BitPos;
        ru     = {{QuotW{1'b0}}, d_in.rem_u};
        rv     = {{QuotW{1'b0}}, d_in.rem_v};
        ge_u   = ru >= den_sh;
        ge_v   = rv >= den_sh;
        d_next = d_in;
        if (ge_u) begin
            d_next.rem_u      = MagW'(ru - den_sh);
            d_next.q_u[BitPos] = 1'b1;
        end
        if (ge_v) begin
            d_next.rem_v      = MagW'(rv - den_sh);
            d_next.q_v[BitPos] = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            d_reg <= d_next;
            p_reg <= p_in;
        end
    end

    assign d_out = d_reg;
    assign p_out = p_reg;
endmodule

>>> rtl/lpcp_row_mac.sv
module lpcp_row_mac (
    input  logic                          aclk,
    input  logic                          en,
    input  logic [lpcp_pkg::CfgW-1:0]     pair_a,
    input  logic [lpcp_pkg::CfgW-1:0]     pair_b,
    input  lpcp_pkg::point_t              p_in,
    output logic signed [lpcp_pkg::AccW-1:0] sum
);
    import lpcp_pkg::*;

    logic signed [ProdW-1:0] px_reg;
    logic signed [ProdW-1:0] py_reg;
    logic signed [ProdW-1:0] pz_reg;
    logic signed [ProdW-1:0] pt_reg;
    logic signed [AccW-1:0]  sum_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            px_reg <= $signed(pair_a[31:0])  * $signed(p_in.x);
            py_reg <= $signed(pair_a[63:32]) * $signed(p_in.y);
            pz_reg <= $signed(pair_b[31:0])  * $signed(p_in.z);
            pt_reg <= {{16{pair_b[63]}}, pair_b[63:32], 16'd0};
            sum_reg <= AccW'(px_reg) + AccW'(py_reg) + AccW'(pz_reg) + AccW'(pt_reg);
        end
    end

    assign sum = sum_reg;
endmodule

>>> rtl/lpcp_checker.sv
module lpcp_checker (
    input logic         aclk,
    input logic         aresetn,
    input logic         s_tready,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [127:0] m_tdata
);
    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |-> !s_tready) else $error("ready while stalled");
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> ($stable(m_tdata) && m_tvalid)) else $error("data moved");
    a_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tdata[0]) |-> (m_tdata[24:1] == 24'd0)) else $error("pixel not zero");
    a_pad: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[127:125] == 3'd0)) else $error("pad bits set");
endmodule

bind lidar_point_camera_projection_core lpcp_checker u_lpcp_checker (
    .aclk, .aresetn, .s_tready, .m_tvalid, .m_tready, .m_tdata);

>>> test/lidar_point_camera_projection_core_tb.sv
module lidar_point_camera_projection_core_tb;
    import lpcp_pkg::*;

    typedef struct {
        logic        in_view;
        logic [11:0] row;
        logic [11:0] col;
        logic [31:0] x;
        logic [31:0] y;
        logic [31:0] z;
        logic        last;
    } pixel_t;

    class projection_board;
        logic [63:0] coef[6];
        logic [12:0] width;
        logic [12:0] height;
        pixel_t      pending[$];
        int          errors;

        function new();
            foreach (coef[i]) coef[i] = '0;
            width = WidthReset;
            height = HeightReset;
            errors = 0;
        endfunction

        function void set_reg(logic [2:0] idx, logic [63:0] val);
            if (idx < RegWidth) begin
                coef[idx] = val;
            end else if (idx == RegWidth) begin
                width = val[12:0];
            end else begin
                height = val[12:0];
            end
        endfunction

        function logic signed [127:0] row_sum(int r, logic signed [31:0] x,
                                               logic signed [31:0] y,
                                               logic signed [31:0] z);
            logic signed [127:0] acc;
            logic [63:0] p0;
            logic [63:0] p1;
            p0 = coef[2 * r];
            p1 = coef[2 * r + 1];
            acc = 128'(signed'(p0[31:0])) * 128'(x);
            acc += 128'(signed'(p0[63:32])) * 128'(y);
            acc += 128'(signed'(p1[31:0])) * 128'(z);
            acc += 128'(signed'(p1[63:32])) * 128'sd65536;
            return acc;
        endfunction

        function bit quotient(logic signed [127:0] n, logic signed [127:0] d,
                              logic [12:0] bound, output logic [11:0] q);
            logic [127:0] nm;
            logic [127:0] dm;
            logic [127:0] qq;
            q = '0;
            if (n != 0 && ((n < 0) != (d < 0))) return 0;
            dm = d < 0 ? -d : d;
            if (dm == 0) return 0;
            nm = n < 0 ? -n : n;
            qq = nm / dm;
            if (qq >= bound) return 0;
            q = qq[11:0];
            return 1;
        endfunction

        function void note_point(logic [95:0] data, logic last);
            pixel_t e;
            logic signed [127:0] u;
            logic signed [127:0] v;
            logic signed [127:0] w;
            logic [12:0] wb;
            logic [12:0] hb;
            logic [11:0] c;
            logic [11:0] r;
            e.x = data[31:0];
            e.y = data[63:32];
            e.z = data[95:64];
            e.last = last;
            wb = width > SizeMax ? SizeMax : width;
            hb = height > SizeMax ? SizeMax : height;
            u = row_sum(0, e.x, e.y, e.z);
            v = row_sum(1, e.x, e.y, e.z);
            w = row_sum(2, e.x, e.y, e.z);
            e.in_view = 0;
            e.row = 0;
            e.col = 0;
            if (!e.x[31] && w != 0) begin
                if (quotient(u, w, wb, c) && quotient(v, w, hb, r)) begin
                    e.in_view = 1;
                    e.row = r;
                    e.col = c;
                end
            end
            pending.insert(pending.size(), e);
        endfunction

        function void check_pixel(logic [127:0] data, logic last);
            pixel_t e;
            pixel_t a;
            a.in_view = data[0];
            a.row = data[12:1];
            a.col = data[24:13];
            a.x = data[56:25];
            a.y = data[88:57];
            a.z = data[120:89];
            a.last = last;
            if (pending.size() == 0) begin
                $display("%0t unexpected transfer %h", $time, data);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (e.in_view !== a.in_view || e.row !== a.row || e.col !== a.col ||
                e.x !== a.x || e.y !== a.y || e.z !== a.z || e.last !== a.last) begin
                $display("%0t expected view=%b row=%0d col=%0d x=%h y=%h z=%h last=%b",
                         $time, e.in_view, e.row, e.col, e.x, e.y, e.z, e.last);
                $display("%0t actual   view=%b row=%0d col=%0d x=%h y=%h z=%h last=%b",
                         $time, a.in_view, a.row, a.col, a.x, a.y, a.z, a.last);
                errors++;
            end
        endfunction
    endclass

    logic         aclk = 0;
    logic         aresetn = 0;
    logic         s_tvalid = 0;
    logic         s_tready;
    logic [95:0]  s_tdata = '0;
    logic         s_tlast = 0;
    logic         m_tvalid;
    logic         m_tready = 0;
    logic [127:0] m_tdata;
    logic         m_tlast;
    logic         cfg_we = 0;
    logic [2:0]   cfg_index = '0;
    logic [63:0]  cfg_data = '0;

    projection_board board = new();
    bit long_hold = 0;
    bit stimulus_done = 0;

    lidar_point_camera_projection_core dut (.*);

    always begin
        #2 aclk = 1;
        #2 aclk = 0;
    end

    task automatic write_reg(logic [2:0] idx, logic [63:0] val);
        cfg_we <= 1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge aclk);
        board.set_reg(idx, val);
    endtask

    task automatic drain();
        s_tvalid <= 0;
        while (board.pending.size() != 0) @(posedge aclk);
        repeat (25) @(posedge aclk);
    endtask

    task automatic send_point(logic [95:0] data, logic last, bit gaps);
        int idle;
        idle = gaps ? $urandom_range(0, 4) : 0;
        if (idle != 0) begin
            s_tvalid <= 0;
            repeat (idle) @(posedge aclk);
        end
        s_tvalid <= 1;
        s_tdata <= data;
        s_tlast <= last;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        board.note_point(data, last);
    endtask

    function automatic logic [31:0] q16(int meters);
        return 32'(meters) << 16;
    endfunction

    function automatic logic [31:0] rand_coord();
        case ($urandom_range(0, 3))
            0: return $urandom();
            1: return 32'($urandom_range(0, 40 << 16));
            2: return -32'($urandom_range(0, 40 << 16));
            default: return 32'($urandom_range(0, 1 << 20)) - 32'(1 << 19);
        endcase
    endfunction

    task automatic camera_setup(logic [12:0] w, logic [12:0] h, bit wild);
        logic [31:0] f;
        f = 32'($urandom_range(100, 800)) << 16;
        if (wild) begin
            for (int i = 0; i < 6; i++) write_reg(3'(i), {$urandom(), $urandom()});
        end else begin
            // Forward axis x maps to depth w; y and z bend into columns and rows.
            write_reg(3'd0, {-f, 32'(w) << 15});
            write_reg(3'd1, {$urandom() & 32'h000f_ffff, 32'h0});
            write_reg(3'd2, {32'h0, 32'(h) << 15});
            write_reg(3'd3, {32'h0, -f});
            write_reg(3'd4, {32'h0, 32'h0001_0000});
            write_reg(3'd5, {32'($urandom_range(0, 3)) << 14, 32'h0});
        end
        write_reg(RegWidth, 64'(w));
        write_reg(RegHeight, 64'(h));
        cfg_we <= 0;
    endtask

    initial begin
        repeat (5) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);
        send_point({q16(5), q16(0), q16(0)}, 1, 0);
        drain();
        camera_setup(13'd640, 13'd480, 0);
        send_point({q16(0), q16(0), q16(10)}, 0, 0);
        send_point({q16(1), q16(-1), q16(10)}, 1, 0);
        send_point({q16(0), q16(0), 32'hffff_ffff}, 0, 0);
        send_point({32'h7fff_ffff, 32'h8000_0000, 32'h0}, 0, 0);
        send_point({32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff}, 1, 0);
        send_point({32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff}, 0, 0);
        send_point({q16(0), q16(0), q16(0)}, 0, 0);
        send_point({q16(-3), q16(3), q16(1)}, 0, 0);
        send_point({q16(30), q16(-30), q16(1)}, 1, 0);
        drain();
        camera_setup(13'd8191, 13'd5000, 0);
        send_point({q16(2), q16(-2), q16(4)}, 0, 0);
        send_point({32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff}, 1, 0);
        drain();
        camera_setup(13'd0, 13'd1, 0);
        send_point({q16(0), q16(0), q16(4)}, 0, 0);
        drain();
        camera_setup(13'd1, 13'd4096, 0);
        send_point({q16(0), q16(0), q16(4)}, 1, 0);
        drain();
        for (int phase = 0; phase < 6; phase++) begin
            case (phase)
                0: camera_setup(13'd640, 13'd480, 0);
                1: camera_setup(13'd4096, 13'd4096, 0);
                2: camera_setup(13'($urandom_range(1, 64)), 13'($urandom_range(1, 64)), 0);
                3: camera_setup(13'($urandom_range(0, 8191)), 13'($urandom_range(0, 8191)), 1);
                4: camera_setup(13'd1, 13'd1, 0);
                default: camera_setup(13'($urandom_range(100, 2000)),
                                      13'($urandom_range(100, 2000)), 0);
            endcase
            if (phase == 2) long_hold = 1;
            for (int n = 0; n < 150; n++)
                send_point({rand_coord(), rand_coord(), rand_coord()},
                           $urandom_range(0, 15) == 0, $urandom_range(0, 2) == 0);
            long_hold = 0;
            if (phase == 3) begin
                drain();
            end else begin
                s_tvalid <= 0;
                while (board.pending.size() != 0) @(posedge aclk);
            end
            repeat (25) @(posedge aclk);
        end
        stimulus_done = 1;
    end

    always @(posedge aclk) begin
        if (m_tvalid && m_tready) board.check_pixel(m_tdata, m_tlast);
    end

    initial begin
        int stall;
        @(posedge aresetn);
        forever begin
            if (long_hold) begin
                m_tready <= 0;
                repeat (200) @(posedge aclk);
                long_hold = 0;
            end
            stall = $urandom_range(0, 1) ? 0 : $urandom_range(0, 4);
            m_tready <= stall == 0;
            @(posedge aclk);
            if (stall != 0) begin
                repeat (stall - 1) @(posedge aclk);
                m_tready <= 1;
                @(posedge aclk);
            end
        end
    end

    initial begin
        wait (stimulus_done);
        repeat (30) @(posedge aclk);
        if (board.errors == 0 && board.pending.size() == 0) begin
            $display("lidar_point_camera_projection_core: match");
        end else begin
            $display("lidar_point_camera_projection_core: mismatch");
        end
        $finish;
    end

    initial begin
        #400000;
        $display("lidar_point_camera_projection_core: mismatch");
        $finish;
    end

endmodule

>>> filelist.f
rtl/lpcp_pkg.sv
rtl/lpcp_div_cell.sv
rtl/lpcp_row_mac.sv
rtl/lidar_point_camera_projection_core.sv
rtl/lpcp_checker.sv
test/lidar_point_camera_projection_core_tb.sv
